FILE: rtl/ode23_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ode23_pkg
// Shared types, constants, microprogram and saturation helper for the
// Bogacki-Shampine transfer function step block.
// ----------------------------------------------------------------------------
package ode23_pkg;

    localparam int DATA_W    = 32;
    localparam int OPND_W    = 33;
    localparam int PROD_W    = 66;
    localparam int ACC_W     = 52;
    localparam int CFG_IDX_W = 4;
    localparam int PC_W      = 4;
    localparam int NUM_STAGES = 4;
    localparam int KIDX_W    = 2;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    typedef logic [PC_W-1:0]      pc_t;

    localparam cfg_idx_t REG_STEP_SIZE   = 4'd0;
    localparam cfg_idx_t REG_FB_1        = 4'd1;
    localparam cfg_idx_t REG_FB_3        = 4'd3;
    localparam cfg_idx_t REG_OUT_1       = 4'd4;
    localparam cfg_idx_t REG_OUT_3       = 4'd6;
    localparam cfg_idx_t REG_FEEDTHROUGH = 4'd7;

    localparam logic [DATA_W-1:0] STEP_SIZE_RESET = 32'd42949673;

    // Unsigned Q0.32 weights
    localparam logic [DATA_W-1:0] W_NONE = 32'd0;
    localparam logic [DATA_W-1:0] W_HALF = 32'd2147483648;
    localparam logic [DATA_W-1:0] W_3_4  = 32'd3221225472;
    localparam logic [DATA_W-1:0] W_2_9  = 32'd954437177;
    localparam logic [DATA_W-1:0] W_1_3  = 32'd1431655765;
    localparam logic [DATA_W-1:0] W_4_9  = 32'd1908874354;
    localparam logic [DATA_W-1:0] W_7_24 = 32'd1252698795;
    localparam logic [DATA_W-1:0] W_1_4  = 32'd1073741824;
    localparam logic [DATA_W-1:0] W_1_8  = 32'd536870912;

    localparam logic signed [PROD_W-1:0] RND_Q16 = 66'sd32768;
    localparam logic signed [PROD_W-1:0] RND_Q32 = 66'sd2147483648;

    localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7fffffff;
    localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh80000000;

    typedef enum logic {
        S_IDLE,
        S_RUN
    } state_t;

    typedef enum logic [1:0] {
        OP_DERIVE,
        OP_ADVANCE,
        OP_OUTPUT
    } opc_t;

    typedef struct packed {
        opc_t               opc;
        logic [DATA_W-1:0]  weight;
        logic [KIDX_W-1:0]  kidx;
        logic               to_state;
    } op_t;

    localparam pc_t PC_LAST = 4'd13;

    // Step microprogram: stage derivatives, stage advances, final update, output
    function automatic op_t prog_op(input pc_t pc);
        op_t op;
        op = '{OP_OUTPUT, W_NONE, 2'd0, 1'b0};
        unique case (pc)
            4'd0:    op = '{OP_DERIVE,  W_NONE, 2'd0, 1'b0};
            4'd1:    op = '{OP_ADVANCE, W_HALF, 2'd0, 1'b0};
            4'd2:    op = '{OP_DERIVE,  W_NONE, 2'd1, 1'b0};
            4'd3:    op = '{OP_ADVANCE, W_3_4,  2'd1, 1'b0};
            4'd4:    op = '{OP_DERIVE,  W_NONE, 2'd2, 1'b0};
            4'd5:    op = '{OP_ADVANCE, W_2_9,  2'd0, 1'b0};
            4'd6:    op = '{OP_ADVANCE, W_1_3,  2'd1, 1'b0};
            4'd7:    op = '{OP_ADVANCE, W_4_9,  2'd2, 1'b0};
            4'd8:    op = '{OP_DERIVE,  W_NONE, 2'd3, 1'b0};
            4'd9:    op = '{OP_ADVANCE, W_7_24, 2'd0, 1'b1};
            4'd10:   op = '{OP_ADVANCE, W_1_4,  2'd1, 1'b1};
            4'd11:   op = '{OP_ADVANCE, W_1_3,  2'd2, 1'b1};
            4'd12:   op = '{OP_ADVANCE, W_1_8,  2'd3, 1'b1};
            PC_LAST: op = '{OP_OUTPUT,  W_NONE, 2'd0, 1'b0};
            default: ;
        endcase
        return op;
    endfunction

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-DATA_W:0] top;
        top = v[ACC_W-1:DATA_W-1];
        if ((&top) || (~|top)) begin
            return v[DATA_W-1:0];
        end
        else if (v[ACC_W-1]) begin
            return SAT_MIN;
        end
        else begin
            return SAT_MAX;
        end
    endfunction

endpackage
`default_nettype wire

FILE: rtl/ode23_transfer_function_step_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ode23_transfer_function_step_top
// Linear plant in controllable canonical form, one Bogacki-Shampine step per
// advance beat, Q16.16 saturating arithmetic on one shared multiplier.
// ----------------------------------------------------------------------------
// An advance beat runs from acceptance to the response register on the single
// 33x33 multiply-add unit that a microprogram walks through four stage
// derivatives, nine scaled-step advances and the output dot product; in_ready
// is low for that whole time.
// A clear beat zeroes the state as it is accepted and returns no response. The
// response register lets the next beat be accepted before the previous
// response is taken; the last cycle waits only if that response is still
// pending. Config writes are always taken and must only occur while idle.
module ode23_transfer_function_step_top
    import ode23_pkg::*;
#(
    parameter int ORDER = 3
)(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [DATA_W-1:0]        cfg_data,

    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     action,
    input  logic signed [DATA_W-1:0] sample,

    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [DATA_W-1:0] response
);

    localparam int STEP_W = $clog2(ORDER + 2);
    localparam logic [STEP_W-1:0] STEP_N  = STEP_W'(ORDER);
    localparam logic [STEP_W-1:0] STEP_N1 = STEP_W'(ORDER + 1);
    localparam logic [STEP_W-1:0] STEP_1  = STEP_W'(1);
    localparam logic [STEP_W-1:0] STEP_2  = STEP_W'(2);

    state_t state_reg, state_next;
    pc_t    pc_reg, pc_next;
    logic [STEP_W-1:0] step_reg, step_next;

    logic [DATA_W-1:0]        step_size_reg;
    logic signed [DATA_W-1:0] fb_reg [ORDER];
    logic signed [DATA_W-1:0] oc_reg [ORDER];
    logic signed [DATA_W-1:0] ff_reg;

    logic signed [DATA_W-1:0] st_reg  [ORDER];
    logic signed [DATA_W-1:0] tmp_reg [ORDER];
    logic signed [DATA_W-1:0] k_reg   [NUM_STAGES][ORDER];

    logic signed [DATA_W-1:0] u_reg;
    logic [DATA_W-1:0]        g_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [DATA_W-1:0] resp_reg;
    logic                     out_valid_reg;

    op_t  op;
    logic is_derive, is_adv, is_out;
    logic op_last, out_stall, run, in_accept;
    logic [STEP_W-1:0] issue_e, cons_e, tmp_idx, st_idx;

    logic signed [DATA_W-1:0] tmp_rd, st_rd, fb_rd, oc_rd, k_rd, x_rd;
    logic signed [OPND_W-1:0] mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_rnd, prod_next;
    logic signed [ACC_W-1:0]  acc_sum, upd_sum;
    logic signed [DATA_W-1:0] acc_sat, upd_sat;
    logic                     adv_cons, st_we, tmp_we;

    // ------------------------------------------------------------------
    // Sequencer control
    // ------------------------------------------------------------------
    assign op        = prog_op(pc_reg);
    assign is_derive = (op.opc == OP_DERIVE);
    assign is_adv    = (op.opc == OP_ADVANCE);
    assign is_out    = (op.opc == OP_OUTPUT);
    assign op_last   = (step_reg == (is_derive ? STEP_N : STEP_N1));
    assign out_stall = is_out && op_last && out_valid_reg && !out_ready;
    assign run       = (state_reg == S_RUN) && !out_stall;
    assign in_accept = in_valid && in_ready;

    assign issue_e = is_derive ? step_reg : step_reg - STEP_1;
    assign cons_e  = is_derive ? step_reg - STEP_1 : step_reg - STEP_2;
    assign tmp_idx = is_derive ? issue_e : cons_e;
    assign st_idx  = is_out ? issue_e : cons_e;

    assign adv_cons = run && is_adv && (step_reg >= STEP_2);
    assign st_we    = adv_cons && op.to_state;
    assign tmp_we   = adv_cons && !op.to_state;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept && !action)
                begin
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                if (run && op_last && (pc_reg == PC_LAST))
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        pc_next   = pc_reg;
        step_next = step_reg;
        if (in_accept)
        begin
            pc_next   = '0;
            step_next = '0;
        end
        else if (run)
        begin
            if (op_last)
            begin
                step_next = '0;
                pc_next   = (pc_reg == PC_LAST) ? '0 : pc_reg + pc_t'(1);
            end
            else
            begin
                step_next = step_reg + STEP_1;
            end
        end
    end

    always_comb
    begin
        in_ready  = (state_reg == S_IDLE);
        cfg_ready = 1'b1;
        out_valid = out_valid_reg;
        response  = resp_reg;
    end

    // ------------------------------------------------------------------
    // Element reads
    // ------------------------------------------------------------------
    always_comb
    begin
        tmp_rd = '0;
        st_rd  = '0;
        fb_rd  = '0;
        oc_rd  = '0;
        k_rd   = '0;
        for (int i = 0; i < ORDER; i++)
        begin
            if (tmp_idx == STEP_W'(i)) tmp_rd = tmp_reg[i];
            if (st_idx == STEP_W'(i))  st_rd  = st_reg[i];
            if (issue_e == STEP_W'(i))
            begin
                fb_rd = fb_reg[i];
                oc_rd = oc_reg[i];
                k_rd  = k_reg[op.kidx][i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Shared multiply-add unit
    // ------------------------------------------------------------------
    always_comb
    begin
        mul_a   = '0;
        mul_b   = '0;
        mul_rnd = RND_Q16;
        unique case (op.opc)
            OP_DERIVE:
            begin
                mul_a = {fb_rd[DATA_W-1], fb_rd};
                mul_b = {tmp_rd[DATA_W-1], tmp_rd};
            end
            OP_ADVANCE:
            begin
                mul_rnd = RND_Q32;
                if (step_reg == '0)
                begin
                    mul_a = {1'b0, op.weight};
                    mul_b = {1'b0, step_size_reg};
                end
                else
                begin
                    mul_a = {1'b0, (step_reg == STEP_1) ? prod_reg[2*DATA_W-1:DATA_W] : g_reg};
                    mul_b = {k_rd[DATA_W-1], k_rd};
                end
            end
            OP_OUTPUT:
            begin
                if (step_reg == '0)
                begin
                    mul_a = {ff_reg[DATA_W-1], ff_reg};
                    mul_b = {u_reg[DATA_W-1], u_reg};
                end
                else
                begin
                    mul_a = {oc_rd[DATA_W-1], oc_rd};
                    mul_b = {st_rd[DATA_W-1], st_rd};
                end
            end
            default: ;
        endcase
    end

    assign prod_next = mul_a * mul_b + mul_rnd;

    // Q16.16 product term and scaled-step increment, both already rounded
    assign acc_sum = acc_reg
                   + {{(ACC_W-PROD_W+16){prod_reg[PROD_W-1]}}, prod_reg[PROD_W-1:16]};
    assign acc_sat = sat32(acc_sum);

    assign x_rd    = op.to_state ? st_rd : tmp_rd;
    assign upd_sum = {{(ACC_W-DATA_W){x_rd[DATA_W-1]}}, x_rd}
                   + {{(ACC_W-PROD_W+DATA_W){prod_reg[PROD_W-1]}}, prod_reg[PROD_W-1:DATA_W]};
    assign upd_sat = sat32(upd_sum);

    // ------------------------------------------------------------------
    // Control and state registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pc_reg        <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            step_reg  <= step_next;
            if (run && is_out && op_last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Clear beat zeroes the plant state; final-update advances write it back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ORDER; i++)
            begin
                st_reg[i] <= '0;
            end
        end
        else if (in_accept && action)
        begin
            for (int i = 0; i < ORDER; i++)
            begin
                st_reg[i] <= '0;
            end
        end
        else if (st_we)
        begin
            for (int i = 0; i < ORDER; i++)
            begin
                if (cons_e == STEP_W'(i)) st_reg[i] <= upd_sat;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_size_reg <= STEP_SIZE_RESET;
            ff_reg        <= '0;
            for (int i = 0; i < ORDER; i++)
            begin
                fb_reg[i] <= '0;
                oc_reg[i] <= '0;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index) inside
                REG_STEP_SIZE: step_size_reg <= cfg_data;
                [REG_FB_1:REG_FB_3]:
                begin
                    for (int i = 0; i < ORDER; i++)
                    begin
                        if ((cfg_index - REG_FB_1) == CFG_IDX_W'(i)) fb_reg[i] <= cfg_data;
                    end
                end
                [REG_OUT_1:REG_OUT_3]:
                begin
                    for (int i = 0; i < ORDER; i++)
                    begin
                        if ((cfg_index - REG_OUT_1) == CFG_IDX_W'(i)) oc_reg[i] <= cfg_data;
                    end
                end
                REG_FEEDTHROUGH: ff_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_accept && !action)
        begin
            u_reg <= sample;
            for (int i = 0; i < ORDER; i++)
            begin
                tmp_reg[i] <= st_reg[i];
            end
        end
        else if (run)
        begin
            prod_reg <= prod_next;
            if (step_reg == '0)
            begin
                acc_reg <= is_derive ? {{(ACC_W-DATA_W){u_reg[DATA_W-1]}}, u_reg} : '0;
            end
            else
            begin
                acc_reg <= acc_sum;
            end
            if (is_adv && (step_reg == STEP_1))
            begin
                g_reg <= prod_reg[2*DATA_W-1:DATA_W];
            end
            if (tmp_we)
            begin
                for (int i = 0; i < ORDER; i++)
                begin
                    if (cons_e == STEP_W'(i)) tmp_reg[i] <= upd_sat;
                end
            end
            // derivative done: first element from feedback sum, rest shifted
            if (is_derive && op_last)
            begin
                k_reg[op.kidx][0] <= acc_sat;
                for (int i = 1; i < ORDER; i++)
                begin
                    k_reg[op.kidx][i] <= tmp_reg[i-1];
                end
                for (int i = 0; i < ORDER; i++)
                begin
                    tmp_reg[i] <= st_reg[i];
                end
            end
            if (is_out && op_last)
            begin
                resp_reg <= acc_sat;
            end
        end
    end

`ifndef SYNTHESIS
    a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN) |-> (pc_reg <= PC_LAST))
        else $error("program counter past end");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= STEP_N1)
        else $error("step counter out of range");

    a_resp_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_RUN && pc_reg == PC_LAST && op_last))
        else $error("response raised outside output op");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && action) |=> (state_reg == S_IDLE && st_reg[0] == '0))
        else $error("clear beat did not zero state");

    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !action) |=>
            (state_reg == S_RUN && pc_reg == '0 && step_reg == '0))
        else $error("advance beat did not start program");
`endif

endmodule
`default_nettype wire

FILE: tb/sv/ode23_transfer_function_step_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ode23_transfer_function_step_top_tb
// Self-checking bench for the Bogacki-Shampine transfer function step block.
// A bit-exact plant predictor tracks the state and registers and queues one
// expected response per advance beat. A clear beat queues nothing. Each later
// phase loads a register set while the block is idle: nominal, random and
// extreme values, plus unmapped indexes. Each phase then streams directed or
// random beats. Both sides idle at random, and at times do not idle at all.
// The receiver also holds off long enough to back the block up.
// ----------------------------------------------------------------------------
module ode23_transfer_function_step_top_tb;
    import ode23_pkg::*;

    localparam int PLANT_ORDER  = 3;
    localparam int CLK_PERIOD   = 4;
    localparam int STEP_LATENCY = 14 * PLANT_ORDER + 24;
    localparam int DRAIN_CYCLES = STEP_LATENCY + 20;
    localparam int IDLE_PCT     = 36;
    localparam int HOLD_CYCLES  = 500;

    localparam logic ACT_ADVANCE = 1'b0;
    localparam logic ACT_CLEAR   = 1'b1;

    localparam cfg_idx_t IDX_FB_2         = REG_FB_1 + 4'd1;
    localparam cfg_idx_t IDX_OUT_2        = REG_OUT_1 + 4'd1;
    localparam cfg_idx_t IDX_UNMAPPED     = REG_FEEDTHROUGH + 4'd1;
    localparam cfg_idx_t IDX_UNMAPPED_TOP = '1;

    localparam logic signed [DATA_W-1:0] Q_ONE = 32'sh0001_0000;

    typedef logic signed [DATA_W-1:0] q16_t;
    typedef logic [PLANT_ORDER-1:0][DATA_W-1:0] plant_vec_t;
    typedef struct packed {
        logic action;
        q16_t sample;
    } step_beat_t;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [DATA_W-1:0]        cfg_data;
    logic                     in_valid;
    logic                     in_ready;
    logic                     action;
    logic signed [DATA_W-1:0] sample;
    logic                     out_valid;
    logic                     out_ready;
    logic signed [DATA_W-1:0] response;

    // predictor registers and plant state
    logic [DATA_W-1:0] step_size_m;
    plant_vec_t        fb_coef_m;
    plant_vec_t        out_coef_m;
    q16_t              feedthrough_m;
    plant_vec_t        plant_x;

    step_beat_t step_queue[$];
    q16_t       expected_response_q[$];
    step_beat_t next_beat;
    logic       in_beat_taken;
    int         send_idle_pct;
    int         recv_idle_pct;
    int         rx_hold_left;
    int         fail_count;

    ode23_transfer_function_step_top #(
        .ORDER(PLANT_ORDER)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .sample    (sample),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .response  (response)
    );

    function automatic q16_t clamp32(input longint v);
        if (v > longint'(SAT_MAX))
        begin
            return SAT_MAX;
        end
        if (v < longint'(SAT_MIN))
        begin
            return SAT_MIN;
        end
        return q16_t'(v);
    endfunction

    function automatic longint q16_mul(input q16_t a, input q16_t b);
        return (longint'(a) * longint'(b) + 64'sd32768) >>> 16;
    endfunction

    function automatic logic [DATA_W-1:0] scaled_step(input logic [DATA_W-1:0] w);
        logic [63:0] p;
        p = {32'd0, w} * {32'd0, step_size_m} + 64'd2147483648;
        return p[63:32];
    endfunction

    function automatic plant_vec_t stage_rate(input q16_t u, input plant_vec_t x);
        plant_vec_t d;
        longint     acc;
        d   = '0;
        acc = longint'(u);
        for (int i = 0; i < PLANT_ORDER; i++)
        begin
            acc += q16_mul(fb_coef_m[i], x[i]);
            if (i + 1 < PLANT_ORDER)
            begin
                d[i+1] = x[i];
            end
        end
        d[0] = clamp32(acc);
        return d;
    endfunction

    function automatic plant_vec_t nudge_state(input logic [DATA_W-1:0] w,
                                               input plant_vec_t k, input plant_vec_t x);
        longint g;
        longint inc;
        q16_t   ki;
        q16_t   xi;
        g = longint'(scaled_step(w));
        for (int i = 0; i < PLANT_ORDER; i++)
        begin
            ki   = k[i];
            xi   = x[i];
            inc  = (g * longint'(ki) + 64'sd2147483648) >>> 32;
            x[i] = clamp32(longint'(xi) + inc);
        end
        return x;
    endfunction

    task automatic take_step(input logic act, input q16_t u);
        plant_vec_t k1, k2, k3, k4, t;
        longint     acc;
        if (act == ACT_CLEAR)
        begin
            plant_x = '0;
            return;
        end
        k1 = stage_rate(u, plant_x);
        t  = nudge_state(W_HALF, k1, plant_x);
        k2 = stage_rate(u, t);
        t  = nudge_state(W_3_4, k2, plant_x);
        k3 = stage_rate(u, t);
        t  = nudge_state(W_2_9, k1, plant_x);
        t  = nudge_state(W_1_3, k2, t);
        t  = nudge_state(W_4_9, k3, t);
        k4 = stage_rate(u, t);
        plant_x = nudge_state(W_7_24, k1, plant_x);
        plant_x = nudge_state(W_1_4, k2, plant_x);
        plant_x = nudge_state(W_1_3, k3, plant_x);
        plant_x = nudge_state(W_1_8, k4, plant_x);
        acc = q16_mul(feedthrough_m, u);
        for (int i = 0; i < PLANT_ORDER; i++)
        begin
            acc += q16_mul(out_coef_m[i], plant_x[i]);
        end
        expected_response_q = {expected_response_q, clamp32(acc)};
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_STEP_SIZE:   step_size_m   = data;
            REG_FB_1:        fb_coef_m[0]  = data;
            IDX_FB_2:        fb_coef_m[1]  = data;
            REG_FB_3:        fb_coef_m[2]  = data;
            REG_OUT_1:       out_coef_m[0] = data;
            IDX_OUT_2:       out_coef_m[1] = data;
            REG_OUT_3:       out_coef_m[2] = data;
            REG_FEEDTHROUGH: feedthrough_m = data;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_plant(input logic [DATA_W-1:0] h,
                              input q16_t fb1, input q16_t fb2, input q16_t fb3,
                              input q16_t c1, input q16_t c2, input q16_t c3,
                              input q16_t ft);
        write_reg(REG_STEP_SIZE, h);
        write_reg(REG_FB_1, fb1);
        write_reg(IDX_FB_2, fb2);
        write_reg(REG_FB_3, fb3);
        write_reg(REG_OUT_1, c1);
        write_reg(IDX_OUT_2, c2);
        write_reg(REG_OUT_3, c3);
        write_reg(REG_FEEDTHROUGH, ft);
    endtask

    task automatic queue_beat(input logic act, input q16_t u);
        step_beat_t b;
        b.action = act;
        b.sample = u;
        step_queue = {step_queue, b};
    endtask

    function automatic q16_t pick_sample();
        if ($urandom_range(99) < 20)
        begin
            return $urandom;
        end
        // mostly within +/-8.0 so the plant stays off the rails
        return $signed($urandom_range(32'h0010_0000)) - 32'sh0008_0000;
    endfunction

    function automatic q16_t pick_small(input int span_q16);
        return $signed($urandom_range(2 * span_q16)) - span_q16;
    endfunction

    task automatic queue_random(input int n, input int clear_pct);
        for (int i = 0; i < n; i++)
        begin
            queue_beat(($urandom_range(99) < clear_pct) ? ACT_CLEAR : ACT_ADVANCE,
                       pick_sample());
        end
    endtask

    task automatic wait_drained();
        while (step_queue.size() != 0 || in_valid || expected_response_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        wait_drained();
        // a clear beat may still be in flight with nothing expected
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // input beat driver
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_beat_taken))
        begin
            in_beat_taken = 1'b0;
            if (step_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_beat = step_queue.pop_front();
                in_valid <= 1'b1;
                action   <= next_beat.action;
                sample   <= next_beat.sample;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            take_step(action, sample);
            in_beat_taken = 1'b1;
        end
    end

    // response receiver with counted hold-off
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (rx_hold_left > 0)
            begin
                out_ready <= 1'b0;
                rx_hold_left--;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_response_q.size() == 0)
            begin
                $error("response: expected none, got %0d", response);
                fail_count++;
            end
            else if (response !== expected_response_q[0])
            begin
                $error("response: expected %0d, got %0d", expected_response_q[0], response);
                fail_count++;
                void'(expected_response_q.pop_front());
            end
            else
            begin
                void'(expected_response_q.pop_front());
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("ode23_transfer_function_step_top: mismatch");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        action        = ACT_ADVANCE;
        sample        = '0;
        out_ready     = 1'b0;
        in_beat_taken = 1'b0;
        send_idle_pct = IDLE_PCT;
        recv_idle_pct = IDLE_PCT;
        rx_hold_left  = 0;
        fail_count    = 0;
        step_size_m   = STEP_SIZE_RESET;
        fb_coef_m     = '0;
        out_coef_m    = '0;
        feedthrough_m = '0;
        plant_x       = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset register values
        queue_beat(ACT_ADVANCE, Q_ONE);
        queue_beat(ACT_ADVANCE, SAT_MAX);
        queue_beat(ACT_CLEAR, '0);
        wait_idle();

        // nominal stable third-order plant, step 0.01 s
        load_plant(STEP_SIZE_RESET, -3 * Q_ONE, -3 * Q_ONE, -Q_ONE,
                   Q_ONE, Q_ONE / 2, Q_ONE / 4, Q_ONE / 2);
        write_reg(IDX_UNMAPPED, $urandom);
        write_reg(IDX_UNMAPPED_TOP, '1);
        queue_beat(ACT_ADVANCE, SAT_MAX);
        queue_beat(ACT_ADVANCE, SAT_MIN);
        queue_beat(ACT_ADVANCE, '0);
        queue_beat(ACT_ADVANCE, 32'sd1);
        queue_beat(ACT_ADVANCE, -32'sd1);
        for (int i = 0; i < 4; i++)
        begin
            queue_beat(ACT_ADVANCE, Q_ONE);
        end
        queue_beat(ACT_CLEAR, SAT_MAX);
        queue_beat(ACT_ADVANCE, Q_ONE);
        queue_beat(ACT_CLEAR, '0);
        queue_beat(ACT_CLEAR, SAT_MIN);
        queue_beat(ACT_ADVANCE, -Q_ONE);
        queue_beat(ACT_ADVANCE, SAT_MIN);
        queue_beat(ACT_ADVANCE, SAT_MIN);
        wait_idle();

        // extreme step and coefficients drive every stage into saturation
        load_plant('1, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MAX);
        queue_beat(ACT_ADVANCE, SAT_MAX);
        queue_beat(ACT_ADVANCE, SAT_MIN);
        queue_beat(ACT_ADVANCE, '0);
        queue_beat(ACT_CLEAR, '0);
        queue_beat(ACT_ADVANCE, SAT_MIN);
        wait_idle();

        // nominal plant under random traffic with a long receiver hold-off
        load_plant(STEP_SIZE_RESET, -3 * Q_ONE, -3 * Q_ONE, -Q_ONE,
                   Q_ONE, Q_ONE / 2, Q_ONE / 4, Q_ONE / 2);
        queue_random(80, 8);
        rx_hold_left = HOLD_CYCLES;
        wait_idle();

        // fully random registers
        load_plant($urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom, $urandom);
        write_reg(IDX_UNMAPPED + cfg_idx_t'($urandom_range(6)), $urandom);
        queue_random(60, 10);
        wait_idle();

        // zero step freezes the state
        load_plant('0, $urandom, $urandom, $urandom,
                   pick_small(4 * Q_ONE), pick_small(4 * Q_ONE), pick_small(4 * Q_ONE),
                   pick_small(4 * Q_ONE));
        queue_random(40, 10);
        wait_idle();

        // random stable-ish plant, back-to-back on both sides
        load_plant($urandom_range(32'h0400_0000, 32'h0040_0000),
                   -$signed($urandom_range(5 * Q_ONE)), -$signed($urandom_range(5 * Q_ONE)),
                   -$signed($urandom_range(2 * Q_ONE)),
                   pick_small(2 * Q_ONE), pick_small(2 * Q_ONE), pick_small(2 * Q_ONE),
                   pick_small(2 * Q_ONE));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random(80, 5);
        wait_idle();
        send_idle_pct = IDLE_PCT;
        recv_idle_pct = IDLE_PCT;

        load_plant('1, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MIN);
        queue_random(40, 10);
        wait_idle();

        // nominal again; sender stops until every response is back, then resumes
        load_plant(STEP_SIZE_RESET, -2 * Q_ONE, -Q_ONE, -Q_ONE / 2,
                   Q_ONE / 2, Q_ONE, -Q_ONE, -Q_ONE / 4);
        queue_random(50, 8);
        wait_drained();
        queue_random(50, 8);
        wait_idle();

        if (fail_count == 0)
        begin
            $display("ode23_transfer_function_step_top: match");
        end
        else
        begin
            $display("ode23_transfer_function_step_top: mismatch");
        end
        $finish;
    end

endmodule
